### hdl/pcd_pkg.sv
// Percent decoder package: character codes, escape phase type, state and
// result structs, hex digit lookup. No dependencies.
`default_nettype none

package pcd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Escape phase, one-hot
    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_HIGH   = 3'b010,
        PH_LOW    = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] high_nibble;
        logic       failed;
    } t_state;

    typedef struct packed {
        logic       have;
        logic [7:0] data;
        logic       last;
        logic       error;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // Hex digit: 0-9, A-F, a-f
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### hdl/pcd_decode.sv
// Per-byte decode step: next escape state and the result for one item.
// Uses pcd_pkg.
`default_nettype none

module pcd_decode (
    input  wire logic           i_plus_as_space,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    input  wire pcd_pkg::t_state i_state,
    output pcd_pkg::t_state     o_state,
    output pcd_pkg::t_result    o_result
);

    pcd_pkg::t_hex hex;

    always_comb begin
        hex      = pcd_pkg::hex_value(i_byte);
        o_state  = i_state;
        o_result = '0;
        o_result.last = i_last;

        if (!i_state.failed) begin
            case (i_state.phase)
                pcd_pkg::PH_HIGH: begin
                    if (!hex.ok || i_last) begin
                        o_state.failed = 1'b1;
                    end else begin
                        o_state.high_nibble = hex.value;
                        o_state.phase       = pcd_pkg::PH_LOW;
                    end
                end
                pcd_pkg::PH_LOW: begin
                    if (!hex.ok) begin
                        o_state.failed = 1'b1;
                    end else begin
                        o_result.have = 1'b1;
                        o_result.data = {i_state.high_nibble, hex.value};
                        o_state.phase = pcd_pkg::PH_NORMAL;
                    end
                end
                default: begin
                    o_state.phase = pcd_pkg::PH_NORMAL;
                    if (i_byte == pcd_pkg::CH_PERCENT) begin
                        if (i_last) begin
                            o_state.failed = 1'b1;
                        end else begin
                            o_state.phase = pcd_pkg::PH_HIGH;
                        end
                    end else if (i_plus_as_space && i_byte == pcd_pkg::CH_PLUS) begin
                        o_result.have = 1'b1;
                        o_result.data = pcd_pkg::CH_SPACE;
                    end else begin
                        o_result.have = 1'b1;
                        o_result.data = i_byte;
                    end
                end
            endcase
        end

        // failed string: swallow until the last byte, then one error item
        if (o_state.failed) begin
            o_result.have  = i_last;
            o_result.data  = 8'h00;
            o_result.error = 1'b1;
        end

        if (i_last) begin
            o_state.phase       = pcd_pkg::PH_NORMAL;
            o_state.high_nibble = 4'd0;
            o_state.failed      = 1'b0;
        end
    end

endmodule

`default_nettype wire

### hdl/percent_decoder.sv
// URL percent decoder, top level: input register, decode step, result register.
// Uses pcd_pkg and pcd_decode.
`default_nettype none

// Decodes one URL component, one byte per item on the slave stream, tlast
// marking the final byte of a string. Ordinary bytes pass through; with
// plus_as_space set, '+' becomes a space; '%' plus exactly two hex digits
// yields the byte they encode ('%' and the first digit give no item). A bad
// digit or an escape cut short by the end of the string fails the string:
// later bytes are swallowed and the last byte gives one item with tuser
// (decode_error) set, tdata zero and tlast set, meaning "discard the string".
// Throughput is one item per cycle while the master side does not stall; a
// taken byte is held in the input register, then decoded into the result
// register that drives the master side. A stalled result holds the input
// register, which in turn drops s_axis_tready in the same cycle. The
// only loop is the escape state update, one short step per byte.
// plus_as_space may be written only while the block is idle; the
// configuration port is always ready.
module percent_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data,      // plus_as_space

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  wire logic       s_axis_tlast,    // in_last

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,    // [7:0] out_byte
    output logic            m_axis_tlast,    // out_last
    output logic            m_axis_tuser     // [0] decode_error
);

    logic              r_plus_as_space;

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    // escape state
    pcd_pkg::t_state   r_state;
    pcd_pkg::t_state   n_state;
    pcd_pkg::t_result  w_result;

    // result register
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    logic              r_out_last;
    logic              r_out_error;

    logic              w_adv;   // input register item moves through decode

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_error;

    pcd_decode u_decode (
        .i_plus_as_space (r_plus_as_space),
        .i_byte          (r_in_byte),
        .i_last          (r_in_last),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_as_space <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_plus_as_space <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // escape state advances once per decoded item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= pcd_pkg::PH_NORMAL;
            r_state.high_nibble <= 4'd0;
            r_state.failed      <= 1'b0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_result.have;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_result.have) begin
            r_out_data  <= w_result.data;
            r_out_last  <= w_result.last;
            r_out_error <= w_result.error;
        end
    end

`ifndef SYNTHESIS
    // an error item is always a zero byte closing the string
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
        else $error("error item not zero or not last");

    // a last byte leaves the escape state clear
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_last |=> !r_state.failed && r_state.phase == pcd_pkg::PH_NORMAL)
        else $error("escape state not cleared at end of string");

    // a held input item is neither lost nor replaced
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input register dropped a held item");

    // a finished result is not overwritten while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !w_adv)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for percent_decoder: directed strings, then random
// URL-like text checked against a behavioural decoder. Depends on pcd_pkg.

module tb_top;

    // How a directed row is checked
    typedef enum logic [1:0] {
        BY_MODEL,   // expectation from the behavioural decoder
        NO_RESULT,  // item is consumed silently
        GIVEN       // expectation typed into the row
    } t_check;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_decoded;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        t_check     chk;
        t_decoded   res;
    } t_row;

    localparam t_decoded NONE_R = '0;
    localparam t_decoded BAD_R  = '{8'h00, 1'b1, 1'b1};  // discard-string item
    localparam int       DIR_N  = 22;

    // Directed strings, decoded with plus_as_space set
    localparam t_row DIR_TAB [DIR_N] = '{
        '{8'h61, 1'b0, BY_MODEL,  NONE_R},                  // 'a' passes
        '{8'h2B, 1'b0, GIVEN,     '{8'h20, 1'b0, 1'b0}},    // '+' -> space
        '{8'h25, 1'b0, NO_RESULT, NONE_R},                  // "%41" -> 'A'
        '{8'h34, 1'b0, NO_RESULT, NONE_R},
        '{8'h31, 1'b0, BY_MODEL,  NONE_R},
        '{8'h25, 1'b0, NO_RESULT, NONE_R},                  // "%fF", mixed case
        '{8'h66, 1'b0, NO_RESULT, NONE_R},
        '{8'h46, 1'b0, GIVEN,     '{8'hFF, 1'b0, 1'b0}},
        '{8'h25, 1'b0, NO_RESULT, NONE_R},                  // "%00"
        '{8'h30, 1'b0, NO_RESULT, NONE_R},
        '{8'h30, 1'b0, GIVEN,     '{8'h00, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, GIVEN,     '{8'hFF, 1'b1, 1'b0}},    // top byte ends string
        '{8'h25, 1'b0, NO_RESULT, NONE_R},                  // bad digit mid string
        '{8'h47, 1'b0, NO_RESULT, NONE_R},
        '{8'h78, 1'b0, NO_RESULT, NONE_R},                  // swallowed
        '{8'h79, 1'b1, GIVEN,     BAD_R},
        '{8'h25, 1'b1, GIVEN,     BAD_R},                   // lone '%' at end
        '{8'h25, 1'b0, NO_RESULT, NONE_R},                  // one digit at end
        '{8'h61, 1'b1, GIVEN,     BAD_R},
        '{8'h25, 1'b0, NO_RESULT, NONE_R},                  // bad digit is last
        '{8'h7A, 1'b1, GIVEN,     BAD_R},
        '{8'h00, 1'b1, GIVEN,     '{8'h00, 1'b1, 1'b0}}     // zero byte, own string
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data    = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic       s_axis_tlast  = 1'b0;   // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // out_last
    logic       m_axis_tuser;           // [0] decode_error

    // Behavioural decoder state
    pcd_pkg::t_phase esc_phase;
    logic [3:0] hi_nib;
    logic       str_failed;
    logic       plus_sp;

    t_decoded   decoded_q [$];  // decoded items still owed by the block
    t_decoded   want_r;
    logic       calm = 1'b0;    // no idling on either side once set
    int         items_sent    = 0;
    int         results_seen  = 0;
    int         errors_seen   = 0;
    int         cfg_writes    = 0;
    int         faults        = 0;

    percent_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Slowest run is roughly 900 items, each with idle gap, sink stall and
    // pipeline delay, about 32 us; this leaves a wide margin.
    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Hex digit value, bit 4 set when the byte is not a digit
    function automatic logic [4:0] digit_of(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd16;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
        end
        return d[4:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return 8'h30 + v;
        end
        return (upper ? 8'h37 : 8'h57) + v;
    endfunction

    function automatic void clear_string();
        esc_phase  = pcd_pkg::PH_NORMAL;
        hi_nib     = 4'h0;
        str_failed = 1'b0;
    endfunction

    // Decodes one accepted byte; returns 1 when the block owes an item for it
    function automatic logic decode_byte(input logic [7:0] b, input logic lst,
                                         output t_decoded r);
        logic [4:0] d;
        logic       have;
        have = 1'b0;
        r    = NONE_R;
        d    = digit_of(b);
        if (!str_failed) begin
            if (esc_phase == pcd_pkg::PH_HIGH || esc_phase == pcd_pkg::PH_LOW) begin
                if (d[4]) begin
                    str_failed = 1'b1;
                end else if (esc_phase == pcd_pkg::PH_HIGH) begin
                    // a high digit cannot end a string
                    if (lst) begin
                        str_failed = 1'b1;
                    end else begin
                        hi_nib    = d[3:0];
                        esc_phase = pcd_pkg::PH_LOW;
                    end
                end else begin
                    r.data    = {hi_nib, d[3:0]};
                    have      = 1'b1;
                    esc_phase = pcd_pkg::PH_NORMAL;
                end
            end else begin
                esc_phase = pcd_pkg::PH_NORMAL;
                if (b == pcd_pkg::CH_PERCENT) begin
                    if (lst) begin
                        str_failed = 1'b1;
                    end else begin
                        esc_phase = pcd_pkg::PH_HIGH;
                    end
                end else if (plus_sp && b == pcd_pkg::CH_PLUS) begin
                    r.data = pcd_pkg::CH_SPACE;
                    have   = 1'b1;
                end else begin
                    r.data = b;
                    have   = 1'b1;
                end
            end
        end
        // a failed string yields one error item on its last byte only
        if (str_failed) begin
            if (lst) begin
                r    = BAD_R;
                have = 1'b1;
                clear_string();
            end
        end else if (have) begin
            r.last = lst;
            if (lst) begin
                clear_string();
            end
        end
        return have;
    endfunction

    task automatic note_fault(input string what, input logic [7:0] want,
                              input logic [7:0] got);
        faults++;
        if (faults <= 10) begin
            $display("[%0t] %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
        end
    endtask

    // Offers one item, with an occasional idle burst ahead of it
    task automatic send_char(input logic [7:0] b, input logic lst, input logic gappy);
        @(negedge i_clk);
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Sender stops until every owed item has come, then lets the pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_plus(input logic v);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        plus_sp = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Builds one string, mostly well formed, and sends it
    task automatic send_random_string();
        logic [7:0] txt [$];
        logic [7:0] v;
        int         n;
        int         pick;
        logic       gappy;
        t_decoded   r;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            v    = 8'($urandom_range(0, 255));
            if (pick < 50) begin
                txt = {txt, (v == pcd_pkg::CH_PERCENT ? pcd_pkg::CH_PLUS : v)};
            end else if (pick < 65) begin
                txt = {txt, pcd_pkg::CH_PLUS};
            end else if (pick < 90) begin
                txt = {txt, pcd_pkg::CH_PERCENT};
                txt = {txt, hex_char(v[7:4], 1'($urandom_range(0, 1)))};
                txt = {txt, hex_char(v[3:0], 1'($urandom_range(0, 1)))};
            end else if (pick < 95) begin
                txt = {txt, v};  // raw noise, may open an escape
            end else begin
                txt = {txt, pcd_pkg::CH_PERCENT};
                txt = {txt, v};
            end
        end
        // now and then the string ends inside an escape
        if ($urandom_range(0, 19) == 0) begin
            txt = {txt, pcd_pkg::CH_PERCENT};
            if ($urandom_range(0, 1)) begin
                txt = {txt, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)))};
            end
        end
        gappy = 1'($urandom_range(0, 1));
        foreach (txt[k]) begin
            send_char(txt[k], k == txt.size() - 1, gappy);
            if (decode_byte(txt[k], k == txt.size() - 1, r)) begin
                decoded_q = {decoded_q, r};
            end
        end
    endtask

    // Sink side: random stall bursts, with quiet stretches between
    initial begin
        int stall;
        int cyc;
        stall = 0;
        cyc   = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else if (!calm && cyc[7:6] != 2'b00 && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                stall = $urandom_range(0, 7);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Checker: every accepted item against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser) begin
                errors_seen++;
            end
            if (decoded_q.size() == 0) begin
                note_fault("item with nothing owed, tdata", 8'h00, m_axis_tdata);
            end else begin
                want_r = decoded_q.pop_front();
                if (m_axis_tdata !== want_r.data) begin
                    note_fault("out_byte", want_r.data, m_axis_tdata);
                end
                if (m_axis_tlast !== want_r.last) begin
                    note_fault("out_last", {7'd0, want_r.last}, {7'd0, m_axis_tlast});
                end
                if (m_axis_tuser !== want_r.err) begin
                    note_fault("decode_error", {7'd0, want_r.err}, {7'd0, m_axis_tuser});
                end
            end
        end
    end

    initial begin
        t_decoded r;
        logic     have;
        int       start;
        plus_sp = 1'b0;
        clear_string();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_plus(1'b1);
        for (int k = 0; k < DIR_N; k++) begin
            send_char(DIR_TAB[k].ch, DIR_TAB[k].lst, 1'b1);
            have = decode_byte(DIR_TAB[k].ch, DIR_TAB[k].lst, r);
            case (DIR_TAB[k].chk)
                BY_MODEL: begin
                    if (have) begin
                        decoded_q = {decoded_q, r};
                    end
                end
                GIVEN: begin
                    decoded_q = {decoded_q, DIR_TAB[k].res};
                end
                default: begin
                end
            endcase
        end

        // Random phases, plus_as_space alternating 0 and 1
        for (int ph = 0; ph < 4; ph++) begin
            write_plus(ph[0]);
            start = items_sent;
            while (items_sent - start < 200) begin
                if (ph == 1 && items_sent - start >= 100 && items_sent - start < 110) begin
                    drain_results();
                end
                if (ph == 3 && items_sent - start >= 100) begin
                    calm = 1'b1;
                end
                send_random_string();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d decoded items (%0d string errors).",
                 items_sent, results_seen, errors_seen);
        $display("plus_as_space written %0d times; %0d mismatches.", cfg_writes, faults);
        if (faults == 0 && decoded_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### percent_decoder.f
hdl/pcd_pkg.sv
hdl/pcd_decode.sv
hdl/percent_decoder.sv
test/tb_top.sv
